[rtl/nfic_pkg.sv]
// ----------------------------------------------------------------------------
// nfic_pkg
// Shared types and constants for the Nova fractal iteration counter.
// ----------------------------------------------------------------------------
package nfic_pkg;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int RADIUS_W  = 31;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RADIUS    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 8'd1;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd256;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	// Sequencer step numbers with a special meaning.
	localparam logic [5:0] STEP_DIV_R = 6'd24;
	localparam logic [5:0] STEP_DIV_I = 6'd25;
	localparam logic [5:0] STEP_LAST  = 6'd32;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_SCALE3,
		OP_SCALE6
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_WAIT_DIV,
		ST_DONE
	} state_t;

	// Saturate a 36-bit exact value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat36(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'(SAT_MAX);
		lo = 36'(SAT_MIN);
		if (v > hi) begin
			sat36 = SAT_MAX;
		end else if (v < lo) begin
			sat36 = SAT_MIN;
		end else begin
			sat36 = v[DATA_W-1:0];
		end
	endfunction

endpackage

[rtl/nfic_in_if.sv]
// ----------------------------------------------------------------------------
// nfic_in_if
// Pixel request channel: valid, ready and the pixel constant c.
// ----------------------------------------------------------------------------
interface nfic_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] c_real;
	logic signed [31:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

[rtl/nfic_out_if.sv]
// ----------------------------------------------------------------------------
// nfic_out_if
// Result channel: valid, ready and the iteration count.
// ----------------------------------------------------------------------------
interface nfic_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] iterations;

	modport source (output valid, output iterations, input ready);
	modport sink   (input valid, input iterations, output ready);
endinterface

[rtl/nfic_cfg_if.sv]
// ----------------------------------------------------------------------------
// nfic_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface nfic_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/nfic_alu.sv]
// ----------------------------------------------------------------------------
// nfic_alu
// Shared fixed-point unit: product, sum, difference and scale by 3 or 6,
// each saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module nfic_alu
	import nfic_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  alu_op_t                  op,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	output logic signed [DATA_W-1:0] y
);

	logic signed [63:0] prod;
	logic signed [63:0] prod_sh;
	logic signed [35:0] a_ext;
	logic signed [35:0] b_ext;
	logic signed [35:0] tri_a;

	assign prod    = 64'(a) * 64'(b);
	// Arithmetic shift rounds toward minus infinity.
	assign prod_sh = prod >>> FRAC_BITS;
	assign a_ext   = 36'(a);
	assign b_ext   = 36'(b);
	assign tri_a   = a_ext + (a_ext <<< 1);

	always_comb begin
		unique case (op)
			OP_MUL: begin
				if (prod_sh > 64'(SAT_MAX)) begin
					y = SAT_MAX;
				end else if (prod_sh < 64'(SAT_MIN)) begin
					y = SAT_MIN;
				end else begin
					y = prod_sh[DATA_W-1:0];
				end
			end
			OP_ADD:    y = sat36(a_ext + b_ext);
			OP_SUB:    y = sat36(a_ext - b_ext);
			OP_SCALE3: y = sat36(tri_a);
			OP_SCALE6: y = sat36(tri_a <<< 1);
			default:   y = '0;
		endcase
	end

endmodule

[rtl/nfic_div.sv]
// ----------------------------------------------------------------------------
// nfic_div
// Bit-serial restoring divider for the fixed-point quotient num / den with
// the magnitude truncated and the result saturated to 32 bits.
// ----------------------------------------------------------------------------
module nfic_div
	import nfic_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic signed [DATA_W-1:0] den,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot
);

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(NW);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] mag_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] q_q;
	logic              ovf_q;
	logic              neg_q;

	logic [DATA_W-1:0] trial;
	logic              ge;

	assign trial = {rem_q[DATA_W-2:0], mag_q[DATA_W-1]};
	assign ge    = (trial >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DATA_W-1];
			mag_q <= num[DATA_W-1] ? (~num + 1'b1) : num;
			d_q   <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			mag_q <= {mag_q[DATA_W-2:0], 1'b0};
			rem_q <= ge ? (trial - d_q) : trial;
			q_q   <= {q_q[DATA_W-2:0], ge};
			ovf_q <= ovf_q | q_q[DATA_W-1];
		end
	end

	always_comb begin
		if (!neg_q) begin
			quot = (ovf_q || q_q[DATA_W-1]) ? SAT_MAX : q_q;
		end else if (ovf_q || (q_q > 32'h8000_0000)) begin
			quot = SAT_MIN;
		end else begin
			quot = ~q_q + 1'b1;
		end
	end

	assign done = done_q;

endmodule

[rtl/nova_fractal_iteration_count.sv]
// ----------------------------------------------------------------------------
// nova_fractal_iteration_count
// Escape-time counter for the relaxed Newton iteration of z^3 - 1.
// ----------------------------------------------------------------------------
// For each pixel request carrying c (signed fixed point, FRAC_BITS fraction
// bits) the block runs z = z - R * f(z) / f'(z) + c from z = 0 until the
// squared magnitude taken before an update reaches relax_radius or the
// count reaches iteration_limit, then returns the count. One request is
// worked on at a time; a new request is taken while the previous result
// still waits in the output register. Each round is a check state and 33
// sequencer steps on one shared saturating multiply/add unit, plus two
// quotients from a bit-serial divider (skipped when the derivative's squared
// magnitude is not positive). The configuration channel is always ready;
// write it only while no request is in flight.
module nova_fractal_iteration_count
	import nfic_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  logic       clk,
	input  logic       arst_n,
	nfic_in_if.sink    pixel,
	nfic_out_if.source result,
	nfic_cfg_if.sink   cfg
);

	// The fixed-point value one saturates when it has no room.
	localparam logic signed [DATA_W-1:0] ONE =
		(FRAC_BITS >= 31) ? SAT_MAX : DATA_W'(64'd1 << FRAC_BITS);

	state_t state_q, state_d;

	logic [RADIUS_W-1:0] radius_q;
	logic [COUNT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  count_q;
	logic [5:0]          step_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_iter_q;

	logic signed [DATA_W-1:0] x_q, y_q, cr_q, ci_q, xn_q;
	logic signed [DATA_W-1:0] x2_q, x3_q, y2_q, y3_q, t_q, u_q;
	logic signed [DATA_W-1:0] fr_q, fi_q, dr_q, di_q, den_q, nr_q, ni_q;
	logic signed [DATA_W-1:0] qr_q, qi_q, r_q;
	logic signed [DATA_W-1:0] radius_s;

	alu_op_t                  alu_op;
	logic signed [DATA_W-1:0] alu_a, alu_b, alu_y;

	logic                     div_start;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_quot;

	logic in_take, keep_going, div_step, den_pos, out_load, step_adv;

	assign radius_s   = DATA_W'({1'b0, radius_q});
	assign in_take    = pixel.valid && pixel.ready;
	assign keep_going = (r_q < radius_s) && (count_q < limit_q);
	assign div_step   = (step_q == STEP_DIV_R) || (step_q == STEP_DIV_I);
	assign den_pos    = (den_q > 0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_take) state_d = ST_CHECK;
			ST_CHECK:    state_d = keep_going ? ST_RUN : ST_DONE;
			ST_RUN: begin
				if (div_step && den_pos) begin
					state_d = ST_WAIT_DIV;
				end else if (step_q == STEP_LAST) begin
					state_d = ST_CHECK;
				end
			end
			ST_WAIT_DIV: if (div_done) state_d = ST_RUN;
			ST_DONE:     if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pixel.ready = (state_q == ST_IDLE);
		div_start   = (state_q == ST_RUN) && div_step && den_pos;
		step_adv    = ((state_q == ST_RUN) && !(div_step && den_pos)) ||
		              ((state_q == ST_WAIT_DIV) && div_done);
		out_load    = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	end

	// Microprogram: operation and operands for each step of a round.
	always_comb begin
		alu_op = OP_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (step_q)
			6'd0:  begin alu_op = OP_MUL;    alu_a = x_q;    alu_b = x_q;  end
			6'd1:  begin alu_op = OP_MUL;    alu_a = x2_q;   alu_b = x_q;  end
			6'd2:  begin alu_op = OP_MUL;    alu_a = y_q;    alu_b = y_q;  end
			6'd3:  begin alu_op = OP_MUL;    alu_a = y2_q;   alu_b = y_q;  end
			6'd4:  begin alu_op = OP_SCALE3; alu_a = x_q;                  end
			6'd5:  begin alu_op = OP_MUL;    alu_a = t_q;    alu_b = y2_q; end
			6'd6:  begin alu_op = OP_SUB;    alu_a = x3_q;   alu_b = t_q;  end
			6'd7:  begin alu_op = OP_SUB;    alu_a = t_q;    alu_b = ONE;  end
			6'd8:  begin alu_op = OP_SCALE3; alu_a = x2_q;                 end
			6'd9:  begin alu_op = OP_MUL;    alu_a = t_q;    alu_b = y_q;  end
			6'd10: begin alu_op = OP_SUB;    alu_a = t_q;    alu_b = y3_q; end
			6'd11: begin alu_op = OP_SUB;    alu_a = x2_q;   alu_b = y2_q; end
			6'd12: begin alu_op = OP_SCALE3; alu_a = t_q;                  end
			6'd13: begin alu_op = OP_SCALE6; alu_a = x_q;                  end
			6'd14: begin alu_op = OP_MUL;    alu_a = t_q;    alu_b = y_q;  end
			6'd15: begin alu_op = OP_MUL;    alu_a = dr_q;   alu_b = dr_q; end
			6'd16: begin alu_op = OP_MUL;    alu_a = di_q;   alu_b = di_q; end
			6'd17: begin alu_op = OP_ADD;    alu_a = t_q;    alu_b = u_q;  end
			6'd18: begin alu_op = OP_MUL;    alu_a = fr_q;   alu_b = dr_q; end
			6'd19: begin alu_op = OP_MUL;    alu_a = fi_q;   alu_b = di_q; end
			6'd20: begin alu_op = OP_ADD;    alu_a = t_q;    alu_b = u_q;  end
			6'd21: begin alu_op = OP_MUL;    alu_a = dr_q;   alu_b = fi_q; end
			6'd22: begin alu_op = OP_MUL;    alu_a = fr_q;   alu_b = di_q; end
			6'd23: begin alu_op = OP_SUB;    alu_a = t_q;    alu_b = u_q;  end
			6'd26: begin alu_op = OP_ADD;    alu_a = x2_q;   alu_b = y2_q; end
			6'd27: begin alu_op = OP_MUL;    alu_a = radius_s; alu_b = qr_q; end
			6'd28: begin alu_op = OP_SUB;    alu_a = x_q;    alu_b = t_q;  end
			6'd29: begin alu_op = OP_ADD;    alu_a = t_q;    alu_b = cr_q; end
			6'd30: begin alu_op = OP_MUL;    alu_a = radius_s; alu_b = qi_q; end
			6'd31: begin alu_op = OP_SUB;    alu_a = y_q;    alu_b = t_q;  end
			6'd32: begin alu_op = OP_ADD;    alu_a = t_q;    alu_b = ci_q; end
			default: begin alu_op = OP_ADD;  alu_a = '0;     alu_b = '0;   end
		endcase
	end

	nfic_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	nfic_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ((step_q == STEP_DIV_R) ? nr_q : ni_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			radius_q    <= ONE[RADIUS_W-1:0];
			limit_q     <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_RELAX_RADIUS) begin
					radius_q <= cfg.data[RADIUS_W-1:0];
				end else if (cfg.index == CFG_ITERATION_LIMIT) begin
					limit_q <= cfg.data[COUNT_W-1:0];
				end
			end
			if (in_take) begin
				count_q <= '0;
			end else if (step_adv && (step_q == STEP_LAST)) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_CHECK) begin
				step_q <= '0;
			end else if (step_adv) begin
				step_q <= step_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			cr_q <= pixel.c_real;
			ci_q <= pixel.c_imag;
			x_q  <= '0;
			y_q  <= '0;
			r_q  <= '0;
		end
		if (out_load) begin
			out_iter_q <= count_q;
		end
		if ((state_q == ST_WAIT_DIV) && div_done) begin
			if (step_q == STEP_DIV_R) begin
				qr_q <= div_quot;
			end else begin
				qi_q <= div_quot;
			end
		end
		if (state_q == ST_RUN) begin
			unique case (step_q)
				6'd0:  x2_q  <= alu_y;
				6'd1:  x3_q  <= alu_y;
				6'd2:  y2_q  <= alu_y;
				6'd3:  y3_q  <= alu_y;
				6'd7:  fr_q  <= alu_y;
				6'd10: fi_q  <= alu_y;
				6'd12: dr_q  <= alu_y;
				6'd14: di_q  <= alu_y;
				6'd16: u_q   <= alu_y;
				6'd17: den_q <= alu_y;
				6'd19: u_q   <= alu_y;
				6'd20: nr_q  <= alu_y;
				6'd22: u_q   <= alu_y;
				6'd23: ni_q  <= alu_y;
				6'd24: if (!den_pos) qr_q <= '0;
				6'd25: if (!den_pos) qi_q <= '0;
				6'd26: r_q   <= alu_y;
				6'd29: xn_q  <= alu_y;
				6'd32: begin
					y_q <= alu_y;
					x_q <= xn_q;
				end
				default: t_q <= alu_y;
			endcase
		end
	end

	assign cfg.ready         = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.iterations = out_iter_q;

	// A finished count always lands in a free output register.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished count was not loaded into the output register");

	// The divider is only started with a positive denominator.
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (den_q > 0))
		else $error("divider started with a non-positive denominator");

	// The round count never passes the limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (count_q <= limit_q))
		else $error("round count passed the iteration limit");

	// The sequencer stays inside the microprogram.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_WAIT_DIV) |-> (step_q <= STEP_LAST))
		else $error("sequencer step out of range");

endmodule
